// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

  // Fixed field widths of the request, result and register interfaces.
  localparam int ADDR_W      = 32;
  localparam int COUNT_OUT_W = 9;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;
  localparam int EXP_W       = 5;

  // Block size exponent limits: 4 bytes up to 2^31 bytes.
  localparam logic [EXP_W-1:0] MIN_EXP = 5'd2;
  localparam logic [EXP_W-1:0] MAX_EXP = 5'd31;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd2;

  // Request kinds.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_OUT  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic cfg_we;
  } fbpa_cmd_t;

  // Rounded block size as a power-of-two exponent: the smallest e with
  // 2^e >= req, at least 2 and at most 31.
  function automatic logic [EXP_W-1:0] size_exp(input logic [ADDR_W-1:0] req);
    logic [ADDR_W-1:0] m;
    logic [EXP_W-1:0]  e;
    m = req - 32'd1;
    e = MIN_EXP;
    if (req > 32'h8000_0000) begin
      e = MAX_EXP;
    end else if (req > 32'd4) begin
      for (int i = 2; i <= 30; i++) begin
        if (m[i]) begin
          e = EXP_W'(i + 1);
        end
      end
    end
    return e;
  endfunction

endpackage

// ===== design/fixed_block_pool_allocator_core.sv =====
// Channel   Direction  tdata / payload                       tuser
// s_*       in         [31:0] free_address                   [0] command
// m_*       out        [31:0] block_address, [33:32] status, -
//                      [42:34] allocated_count, [47:43] zero
// cfg_*     in         cfg_index selects register, cfg_data  -
//
// A request is decided in the cycle it is accepted; its result is shown
// from the next cycle until taken. With the output side ready, one request
// per cycle is sustained; a result that is not taken holds off the next request.
// The stack memory's single port serves either the pop read or the push write.
// Reset and any write to a known register rebuild the stack at once; no clearing pass.
// Register writes are taken only when no result is waiting.
module fixed_block_pool_allocator_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [fbpa_pkg::IN_DATA_W-1:0]      s_tdata,   // [31:0] free_address
  input  logic                                s_tuser,   // [0] command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fbpa_pkg::OUT_DATA_W-1:0]     m_tdata,   // [31:0] block_address,
                                                         // [33:32] status,
                                                         // [42:34] allocated_count
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  logic [ADDR_W-1:0]      block_address;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] allocated_count;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  fbpa_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .command         (s_tuser),
    .free_address    (s_tdata),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .block_address   (block_address),
    .status          (status),
    .allocated_count (allocated_count)
  );

  // Pack the result fields, highest field first.
  assign m_tdata = {5'd0, allocated_count, status, block_address};

endmodule

// ===== design/fbpa_ctrl.sv =====
module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output fbpa_pkg::fbpa_cmd_t cmd
);
  import fbpa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_OUT  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // Register writes are taken only while no result is pending; a request
  // may follow a delivered result in the same cycle.
  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE) ? !cfg_valid : m_tready;
  assign m_tvalid  = (state == S_OUT);
  assign accept    = s_tvalid && s_tready;

  assign cmd.exec   = accept;
  assign cmd.cfg_we = cfg_valid && cfg_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready && !accept) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/fbpa_dpath.sv =====
module fbpa_dpath #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fbpa_pkg::fbpa_cmd_t                 cmd,
  input  logic                                command,
  input  logic [fbpa_pkg::ADDR_W-1:0]         free_address,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [fbpa_pkg::ADDR_W-1:0]         block_address,
  output logic [fbpa_pkg::STATUS_W-1:0]       status,
  output logic [fbpa_pkg::COUNT_OUT_W-1:0]    allocated_count
);
  import fbpa_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW = CW + 31;
  localparam logic [CW-1:0] RESET_BLOCKS = (MAX_BLOCKS < 256) ? CW'(MAX_BLOCKS) : CW'(256);

  // Pool configuration.
  logic [ADDR_W-1:0] base;
  logic [CW-1:0]     n_blocks;
  logic [EXP_W-1:0]  size_e;

  // Stack pointer, in-use count and fill mark. Entries below the mark have
  // not been touched since the last rebuild and read as base + i*size.
  logic [CW-1:0] top;
  logic [CW-1:0] mark;
  logic [CW-1:0] in_use;

  // Result registers.
  logic              res_from_mem;
  logic [ADDR_W-1:0] res_addr;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]     res_count;

  // Free stack storage.
  logic [ADDR_W-1:0] mem [MAX_BLOCKS];
  logic [ADDR_W-1:0] mem_rdata;

  logic [CW-1:0]     n_new;
  logic [CW-1:0]     top_dec;
  logic [ADDR_W-1:0] offset;
  logic [LW-1:0]     limit;
  logic              out_of_range;
  logic              do_pop;
  logic              do_push;
  logic [CFG_DATA_W-1:0] bc_wide;

  assign top_dec      = top - CW'(1);
  assign offset       = free_address - base;
  assign limit        = LW'(n_blocks - CW'(1)) << size_e;
  assign out_of_range = (n_blocks == '0) || (LW'(offset) > limit);
  assign do_pop       = cmd.exec && (command == CMD_ALLOC) && (top != '0);
  assign do_push      = cmd.exec && (command == CMD_FREE) && !out_of_range &&
                        (in_use != '0);

  // The low nine bits of the block count saturate at the pool capacity; higher bits are ignored.
  assign bc_wide = CFG_DATA_W'(cfg_data[8:0]);
  always_comb begin
    n_new = n_blocks;
    if (cfg_index == CFG_COUNT) begin
      n_new = (bc_wide > CFG_DATA_W'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cfg_data[8:0]);
    end
  end

  // Configuration, stack pointers and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      n_blocks <= RESET_BLOCKS;
      size_e   <= MIN_EXP;
      top      <= RESET_BLOCKS;
      mark     <= RESET_BLOCKS;
      in_use   <= '0;
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:  base   <= cfg_data;
        CFG_COUNT: n_blocks <= n_new;
        CFG_SIZE:  size_e <= size_exp(cfg_data);
        default:   ;
      endcase
      // Any known register write rebuilds the stack.
      if (cfg_index == CFG_BASE || cfg_index == CFG_COUNT || cfg_index == CFG_SIZE) begin
        top    <= n_new;
        mark   <= n_new;
        in_use <= '0;
      end
    end else if (do_pop) begin
      top    <= top_dec;
      in_use <= in_use + CW'(1);
      if (top_dec < mark) mark <= top_dec;
    end else if (do_push) begin
      top    <= top + CW'(1);
      in_use <= in_use - CW'(1);
    end
  end

  // Stack memory: push writes at the top, pop reads just below it.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[top[IW-1:0]] <= free_address;
    end
    if (do_pop) begin
      mem_rdata <= mem[top_dec[IW-1:0]];
    end
  end

  // Result of the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_from_mem <= 1'b0;
      res_addr     <= '0;
      if (command == CMD_ALLOC) begin
        if (top == '0) begin
          res_status <= ST_EXHAUSTED;
          res_count  <= in_use;
        end else begin
          res_status   <= ST_OK;
          res_count    <= in_use + CW'(1);
          res_from_mem <= (top != mark);
          res_addr     <= base + (ADDR_W'(top_dec) << size_e);
        end
      end else begin
        if (out_of_range) begin
          res_status <= ST_RANGE;
          res_count  <= in_use;
        end else if (in_use == '0) begin
          res_status <= ST_NONE_OUT;
          res_count  <= in_use;
        end else begin
          res_status <= ST_OK;
          res_count  <= in_use - CW'(1);
        end
      end
    end
  end

  assign block_address   = res_from_mem ? mem_rdata : res_addr;
  assign status          = res_status;
  assign allocated_count = COUNT_OUT_W'(res_count);

endmodule

// ===== verif/tb_fixed_block_pool_allocator_core.sv =====
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  localparam int          POOL_CAPACITY = 256;
  localparam int unsigned CYCLE_LIMIT   = 200_000;

  // Register index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One result as it sits in m_tdata, lowest field last.
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic [STATUS_W-1:0]    status;
    logic [ADDR_W-1:0]      addr;
  } alloc_result_t;

  // Pool predictor and store of expected results.
  class pool_checker;
    logic [ADDR_W-1:0]     base_reg;
    logic [COUNT_OUT_W-1:0] count_reg;
    logic [ADDR_W-1:0]     size_req;
    int unsigned           blocks;
    longint unsigned       block_bytes;
    logic [ADDR_W-1:0]     free_stack [POOL_CAPACITY];
    int unsigned           top;
    int unsigned           in_use;
    logic [ADDR_W-1:0]     handed_out [$];
    alloc_result_t         expected_results [$];
    int unsigned           mismatch_count;

    function new();
      base_reg       = '0;
      count_reg      = 9'd256;
      size_req       = 32'd4;
      mismatch_count = 0;
      rebuild();
    endfunction

    // Refill the free stack from the registers, highest block on top.
    function void rebuild();
      longint unsigned req;
      blocks = (count_reg > POOL_CAPACITY) ? POOL_CAPACITY : count_reg;
      req = (size_req > 32'h8000_0000) ? 64'h8000_0000 : size_req;
      block_bytes = 4;
      while (block_bytes < req) block_bytes = block_bytes << 1;
      for (int i = 0; i < POOL_CAPACITY; i++) begin
        free_stack[i] = (i < blocks) ? ADDR_W'(base_reg + longint'(i) * block_bytes) : '0;
      end
      top    = blocks;
      in_use = 0;
      handed_out.delete();
    endfunction

    // Any known register write rebuilds the pool; other indexes are ignored.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE:  base_reg = data;
        CFG_COUNT: count_reg = data[COUNT_OUT_W-1:0];
        CFG_SIZE:  size_req = data;
        default: return;
      endcase
      rebuild();
    endfunction

    // Decide an accepted request and queue its expected result.
    function void note_request(logic cmd, logic [ADDR_W-1:0] addr);
      alloc_result_t r;
      logic [ADDR_W-1:0] offset;
      r = '0;
      if (cmd == CMD_ALLOC) begin
        if (in_use >= blocks || top == 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          top--;
          r.addr = free_stack[top];
          in_use++;
          handed_out.push_back(r.addr);
        end
      end else begin
        // The range check works on the wrapped offset from the base.
        offset = addr - base_reg;
        if (blocks == 0 || 64'(offset) > 64'(blocks - 1) * block_bytes) begin
          r.status = ST_RANGE;
        end else if (in_use == 0 || top >= POOL_CAPACITY) begin
          r.status = ST_NONE_OUT;
        end else begin
          free_stack[top] = addr;
          top++;
          in_use--;
          for (int k = 0; k < handed_out.size(); k++) begin
            if (handed_out[k] == addr) begin
              handed_out.delete(k);
              break;
            end
          end
        end
      end
      r.count = in_use[COUNT_OUT_W-1:0];
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      if (mismatch_count < 50) $display("pool check at %0t: %s", $time, msg);
      mismatch_count++;
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [OUT_DATA_W-1:0] data);
      alloc_result_t got;
      alloc_result_t want;
      got = data[$bits(alloc_result_t)-1:0];
      if (expected_results.size() == 0) begin
        report($sformatf("result %h arrived with no request outstanding", data));
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      if (got.addr != want.addr)
        report($sformatf("block address %h, expected %h", got.addr, want.addr));
      if (got.status != want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.count != want.count)
        report($sformatf("allocated count %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic                    s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  pool_checker pool;
  bit          steady;
  int unsigned cycle_count;

  fixed_block_pool_allocator_core #(
    .MAX_BLOCKS(POOL_CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) pool.check_result(m_tdata);
      if (cfg_valid && cfg_ready) pool.write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) pool.note_request(s_tuser, s_tdata);
    end
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fixed_block_pool_allocator_core: mismatch");
      $finish;
    end
  end

  // Result side: unless steady, hold ready low for a random stall before each result.
  initial begin : result_sink
    int unsigned hold;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Send one request after a random gap, none when steady; returns at the falling edge after acceptance.
  task automatic send_request(input logic cmd, input logic [IN_DATA_W-1:0] addr);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pool.expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly addresses that are really out, with aligned, edge and random noise mixed in.
  function automatic logic [ADDR_W-1:0] pick_free_address();
    int unsigned       roll;
    int unsigned       slot;
    logic [ADDR_W-1:0] last;
    roll = $urandom_range(0, 99);
    slot = $urandom_range(0, (pool.blocks == 0) ? 0 : pool.blocks - 1);
    last = ADDR_W'(pool.base_reg
                   + longint'((pool.blocks == 0) ? 0 : pool.blocks - 1) * pool.block_bytes);
    if (roll < 70 && pool.handed_out.size() != 0)
      return pool.handed_out[$urandom_range(0, pool.handed_out.size() - 1)];
    if (roll < 80)
      return ADDR_W'(pool.base_reg + longint'(slot) * pool.block_bytes);
    case ($urandom_range(0, 4))
      0: return pool.base_reg - 1;
      1: return last + 1;
      2: return last;
      3: return ADDR_W'(pool.base_reg + longint'(slot) * pool.block_bytes
                        + $urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int unsigned items, input int unsigned alloc_pct);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < alloc_pct) send_request(CMD_ALLOC, $urandom);
      else send_request(CMD_FREE, pick_free_address());
    end
    settle();
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] base_word;
    logic [CFG_DATA_W-1:0] count_word;
    logic [CFG_DATA_W-1:0] size_word;
    int unsigned           items;
    int unsigned           alloc_pct;

    pool        = new();
    steady      = 1'b0;
    cycle_count = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_ALLOC;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_BASE;
    cfg_data    = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset pool: base 0, 256 blocks of 4 bytes.
    send_request(CMD_FREE, 32'h0000_0000);   // nothing allocated yet
    send_request(CMD_FREE, 32'hFFFF_FFFF);   // far out of range
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'd1020);
    send_request(CMD_FREE, 32'd1020);        // same block freed twice
    send_request(CMD_FREE, 32'd1016);        // count already back to zero
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_FREE, 32'd1024);        // one past the last block
    send_request(CMD_FREE, 32'd1021);        // unaligned, past the last block's start: out of range
    send_request(CMD_ALLOC, 32'h0);
    settle();

    // A write to the unused index must leave the allocation in place.
    program_register(CFG_UNUSED, $urandom);
    send_request(CMD_FREE, 32'd1016);
    settle();

    // Empty pool.
    program_register(CFG_COUNT, 32'd0);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_FREE, 32'h0);
    settle();

    // Two blocks straddling the top of the address space, size rounded up.
    program_register(CFG_COUNT, 32'd2);
    program_register(CFG_BASE, 32'hFFFF_FFFC);
    program_register(CFG_SIZE, 32'd3);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'h0);
    send_request(CMD_ALLOC, 32'h0);          // exhausted
    send_request(CMD_FREE, 32'h0000_0004);
    send_request(CMD_FREE, 32'h0000_0000);
    send_request(CMD_FREE, 32'hFFFF_FFFC);
    send_request(CMD_FREE, 32'hFFFF_FFFB);   // just below the base
    settle();

    // Random phases, each on its own pool setting.
    for (int p = 0; p < 10; p++) begin
      steady     = (p == 0) || ($urandom_range(0, 3) == 0);
      items      = 65;
      alloc_pct  = $urandom_range(35, 70);
      base_word  = $urandom;
      count_word = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0: size_word = 32'd1 << $urandom_range(0, 31);
        1: size_word = (32'd1 << $urandom_range(0, 30)) + 1;
        default: size_word = $urandom_range(0, 64);
      endcase
      case (p)
        0: begin
          // Full pool wrapping past zero, filled to exhaustion.
          base_word  = 32'hFFFF_FFF0;
          count_word = 32'hFFFF_FFFF;
          size_word  = 32'd0;
          items      = 300;
          alloc_pct  = 97;
        end
        1: begin
          count_word = 32'd0;
          items      = 30;
        end
        2: begin
          count_word = 32'd1;
          size_word  = 32'h8000_0001;
          alloc_pct  = 50;
        end
        3: begin
          base_word  = 32'd0;
          count_word = 32'd256;
          size_word  = 32'hFFFF_FFFF;
        end
        4: begin
          count_word = 32'h0000_0101;
          size_word  = 32'd1;
        end
        default: ;
      endcase
      program_register(CFG_BASE, base_word);
      program_register(CFG_COUNT, count_word);
      program_register(CFG_SIZE, size_word);
      run_phase(items, alloc_pct);
    end

    steady = 1'b0;
    settle();
    repeat (10) @(negedge clk);
    if (pool.mismatch_count == 0) begin
      $display("fixed_block_pool_allocator_core: match");
    end else begin
      $display("fixed_block_pool_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fbpa_pkg.sv
design/fbpa_ctrl.sv
design/fbpa_dpath.sv
design/fixed_block_pool_allocator_core.sv
verif/tb_fixed_block_pool_allocator_core.sv
